### hw/rtl/ecf_pkg.sv
// Shared types, codes and constants of the Euler circuit finder.
package ecf_pkg;

    localparam int MAX_VERTICES  = 16;
    localparam int DEF_MAX_EDGES = 63;
    localparam int VTX_W         = 4;
    localparam int CFG_W         = 5;

    localparam logic [CFG_W-1:0] NV_RESET = CFG_W'(16);

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_RUN   = 2'd2;

    localparam logic [1:0] KIND_ACCEPT  = 2'd0;
    localparam logic [1:0] KIND_REJECT  = 2'd1;
    localparam logic [1:0] KIND_CLEARED = 2'd2;
    localparam logic [1:0] KIND_VERTEX  = 2'd3;

    typedef struct packed {
        logic [1:0]       mode;
        logic [VTX_W-1:0] src_vertex;
        logic [VTX_W-1:0] dst_vertex;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       result_kind;
        logic [VTX_W-1:0] vertex_out;
        logic             is_eulerian;
        logic             is_last;
    } t_out_word;

    typedef struct packed {
        logic add;
        logic clear;
        logic run_init;
        logic scan_next;
        logic scan_prev;
        logic deg_acc;
        logic bal;
        logic rch_acc;
        logic rch_restart;
        logic rch_end;
        logic walk_init;
        logic push;
        logic pop;
        logic cur_load;
        logic emit_rd;
        logic emit_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic total_zero;
        logic at_last;
        logic at_zero;
        logic balanced;
        logic any_edge;
        logic rch_more;
        logic walk_match;
        logic sp_one;
        logic clen_zero;
    } t_dp_sts;

endpackage

### hw/rtl/ecf_datapath.sv
// Datapath: edge store, degree and reach flags, walk stack and circuit store.
module ecf_datapath
    import ecf_pkg::*;
#(
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_word         i_in_word,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    output t_out_word        o_out_word
);

    localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int SIDX_W = (MAX_EDGES + 1 > 1) ? $clog2(MAX_EDGES + 1) : 1;
    localparam int SP_W   = $clog2(MAX_EDGES + 2);
    localparam int DW     = CNT_W + 1;

    logic [CFG_W-1:0]  r_nv;
    logic [CFG_W-1:0]  nv_eff;

    logic [VTX_W-1:0]  mem_tail [MAX_EDGES];
    logic [VTX_W-1:0]  mem_head [MAX_EDGES];
    logic [VTX_W-1:0]  r_rd_tail;
    logic [VTX_W-1:0]  r_rd_head;
    logic [MAX_EDGES-1:0] r_consumed;
    logic [CNT_W-1:0]  r_total;
    logic [EIDX_W-1:0] r_eidx;
    logic [EIDX_W-1:0] n_eidx;

    logic signed [DW-1:0] r_diff [MAX_VERTICES];
    logic signed [DW-1:0] n_diff [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_has;
    logic [MAX_VERTICES-1:0] n_has;
    logic [MAX_VERTICES-1:0] r_reach;
    logic [MAX_VERTICES-1:0] n_reach;
    logic              r_changed;
    logic              r_eul;

    logic [VTX_W-1:0]  mem_stack [MAX_EDGES + 1];
    logic [VTX_W-1:0]  mem_circ  [MAX_EDGES + 1];
    logic [SP_W-1:0]   r_sp;
    logic [SP_W-1:0]   r_clen;
    logic [VTX_W-1:0]  r_cur;
    logic [VTX_W-1:0]  r_stk_rd;
    logic [VTX_W-1:0]  r_circ_rd;
    t_out_word         r_out;

    logic              live;
    logic              add_ok;
    logic              hit;
    logic              balanced;
    logic              any_edge;
    logic              all_reached;
    logic [VTX_W-1:0]  start_v;

    always_comb begin
        if (r_nv == '0) begin
            nv_eff = CFG_W'(1);
        end else if (r_nv > CFG_W'(MAX_VERTICES)) begin
            nv_eff = CFG_W'(MAX_VERTICES);
        end else begin
            nv_eff = r_nv;
        end
    end

    assign live = !r_consumed[r_eidx] && ({1'b0, r_rd_tail} < nv_eff)
                  && ({1'b0, r_rd_head} < nv_eff);
    assign add_ok = ({1'b0, i_in_word.src_vertex} < nv_eff)
                    && ({1'b0, i_in_word.dst_vertex} < nv_eff)
                    && (r_total < CNT_W'(MAX_EDGES));
    assign hit = live && r_reach[r_rd_tail] && !r_reach[r_rd_head];

    always_comb begin
        n_eidx = r_eidx;
        if (i_cmd.run_init || i_cmd.bal || i_cmd.rch_restart) begin
            n_eidx = '0;
        end else if (i_cmd.scan_next) begin
            n_eidx = r_eidx + EIDX_W'(1);
        end else if (i_cmd.scan_prev) begin
            n_eidx = r_eidx - EIDX_W'(1);
        end else if (i_cmd.walk_init || i_cmd.push || i_cmd.cur_load) begin
            n_eidx = EIDX_W'(r_total - CNT_W'(1));
        end
    end

    always_comb begin
        balanced    = 1'b1;
        any_edge    = 1'b0;
        all_reached = 1'b1;
        start_v     = '0;
        for (int v = MAX_VERTICES - 1; v >= 0; v--) begin
            if (r_diff[v] != '0) begin
                balanced = 1'b0;
            end
            if (r_has[v]) begin
                any_edge = 1'b1;
                start_v  = VTX_W'(v);
                if (!r_reach[v]) begin
                    all_reached = 1'b0;
                end
            end
        end
    end

    always_comb begin
        for (int v = 0; v < MAX_VERTICES; v++) begin
            n_diff[v]  = r_diff[v];
            n_has[v]   = r_has[v];
            n_reach[v] = r_reach[v];
            if (i_cmd.run_init) begin
                n_diff[v] = '0;
                n_has[v]  = 1'b0;
            end else if (i_cmd.deg_acc && live) begin
                if (r_rd_tail == VTX_W'(v)) begin
                    n_diff[v] = n_diff[v] + DW'(1);
                    n_has[v]  = 1'b1;
                end
                if (r_rd_head == VTX_W'(v)) begin
                    n_diff[v] = n_diff[v] - DW'(1);
                    n_has[v]  = 1'b1;
                end
            end
            if (i_cmd.bal) begin
                n_reach[v] = (start_v == VTX_W'(v));
            end else if (i_cmd.rch_acc && hit && (r_rd_head == VTX_W'(v))) begin
                n_reach[v] = 1'b1;
            end
        end
    end

    // Edge store and its read port, addressed by the next scan index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.add && add_ok) begin
            mem_tail[r_total[EIDX_W-1:0]] <= i_in_word.src_vertex;
            mem_head[r_total[EIDX_W-1:0]] <= i_in_word.dst_vertex;
        end
        r_rd_tail <= mem_tail[n_eidx];
        r_rd_head <= mem_head[n_eidx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem_stack[r_sp[SIDX_W-1:0]] <= r_rd_head;
        end else if (i_cmd.walk_init) begin
            mem_stack[0] <= '0;
        end
        r_stk_rd <= mem_stack[SIDX_W'(r_sp - SP_W'(2))];
        if (i_cmd.pop) begin
            mem_circ[r_clen[SIDX_W-1:0]] <= r_cur;
        end
        if (i_cmd.emit_rd) begin
            r_circ_rd <= mem_circ[SIDX_W'(r_clen - SP_W'(1))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv       <= NV_RESET;
            r_consumed <= '0;
            r_total    <= '0;
            r_eidx     <= '0;
            r_has      <= '0;
            r_reach    <= '0;
            r_changed  <= 1'b0;
            r_eul      <= 1'b0;
            r_sp       <= '0;
            r_clen     <= '0;
            r_cur      <= '0;
            for (int v = 0; v < MAX_VERTICES; v++) begin
                r_diff[v] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_nv <= i_cfg_data;
            end
            r_eidx  <= n_eidx;
            r_diff  <= n_diff;
            r_has   <= n_has;
            r_reach <= n_reach;
            if (i_cmd.add && add_ok) begin
                r_consumed[r_total[EIDX_W-1:0]] <= 1'b0;
                r_total <= r_total + CNT_W'(1);
            end
            if (i_cmd.clear) begin
                r_consumed <= '0;
                r_total    <= '0;
            end
            if (i_cmd.bal) begin
                r_changed <= 1'b0;
                r_eul     <= balanced && !any_edge;
            end else if (i_cmd.rch_acc) begin
                r_changed <= i_cmd.rch_restart ? 1'b0 : (r_changed || hit);
            end
            if (i_cmd.rch_end) begin
                r_eul <= all_reached;
            end
            if (i_cmd.walk_init) begin
                r_sp   <= SP_W'(1);
                r_clen <= '0;
                r_cur  <= '0;
            end
            if (i_cmd.push) begin
                r_consumed[r_eidx] <= 1'b1;
                r_sp  <= r_sp + SP_W'(1);
                r_cur <= r_rd_head;
            end
            if (i_cmd.pop) begin
                r_sp   <= r_sp - SP_W'(1);
                r_clen <= r_clen + SP_W'(1);
            end
            if (i_cmd.cur_load) begin
                r_cur <= r_stk_rd;
            end
            if (i_cmd.emit_rd) begin
                r_clen <= r_clen - SP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_out.result_kind <= add_ok ? KIND_ACCEPT : KIND_REJECT;
            r_out.vertex_out  <= '0;
            r_out.is_eulerian <= 1'b0;
            r_out.is_last     <= 1'b1;
        end else if (i_cmd.clear) begin
            r_out.result_kind <= KIND_CLEARED;
            r_out.vertex_out  <= '0;
            r_out.is_eulerian <= 1'b0;
            r_out.is_last     <= 1'b1;
        end else if (i_cmd.emit_ld) begin
            r_out.result_kind <= KIND_VERTEX;
            r_out.vertex_out  <= r_circ_rd;
            r_out.is_eulerian <= r_eul;
            r_out.is_last     <= (r_clen == '0);
        end
    end

    assign o_out_word = r_out;

    assign o_sts.total_zero = (r_total == '0);
    assign o_sts.at_last    = (CNT_W'(r_eidx) + CNT_W'(1) == r_total);
    assign o_sts.at_zero    = (r_eidx == '0);
    assign o_sts.balanced   = balanced;
    assign o_sts.any_edge   = any_edge;
    assign o_sts.rch_more   = r_changed || hit;
    assign o_sts.walk_match = live && (r_rd_tail == r_cur);
    assign o_sts.sp_one     = (r_sp == SP_W'(1));
    assign o_sts.clen_zero  = (r_clen == '0);

endmodule

### hw/rtl/ecf_ctrl.sv
// Controller state machine that sequences load, classification, walk and emit.
module ecf_ctrl
    import ecf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_mode,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DEG       = 4'd1;
    localparam logic [3:0] S_BAL       = 4'd2;
    localparam logic [3:0] S_RCH       = 4'd3;
    localparam logic [3:0] S_RCH_END   = 4'd4;
    localparam logic [3:0] S_WALK_INIT = 4'd5;
    localparam logic [3:0] S_WALK      = 4'd6;
    localparam logic [3:0] S_POP       = 4'd7;
    localparam logic [3:0] S_POP_B     = 4'd8;
    localparam logic [3:0] S_EMIT_RD   = 4'd9;
    localparam logic [3:0] S_EMIT_LD   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_vld;
    logic       n_out_vld;
    logic       out_free;
    logic       accept;

    assign out_free   = !r_out_vld || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        MODE_ADD:   o_cmd.add = 1'b1;
                        MODE_CLEAR: o_cmd.clear = 1'b1;
                        MODE_RUN: begin
                            o_cmd.run_init = 1'b1;
                            n_state = i_sts.total_zero ? S_BAL : S_DEG;
                        end
                        default: ;
                    endcase
                end
            end
            S_DEG: begin
                o_cmd.deg_acc = 1'b1;
                if (i_sts.at_last) begin
                    n_state = S_BAL;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_BAL: begin
                o_cmd.bal = 1'b1;
                n_state = (i_sts.balanced && i_sts.any_edge) ? S_RCH : S_WALK_INIT;
            end
            S_RCH: begin
                o_cmd.rch_acc = 1'b1;
                if (!i_sts.at_last) begin
                    o_cmd.scan_next = 1'b1;
                end else if (i_sts.rch_more) begin
                    o_cmd.rch_restart = 1'b1;
                end else begin
                    n_state = S_RCH_END;
                end
            end
            S_RCH_END: begin
                o_cmd.rch_end = 1'b1;
                n_state = S_WALK_INIT;
            end
            S_WALK_INIT: begin
                o_cmd.walk_init = 1'b1;
                n_state = i_sts.total_zero ? S_POP : S_WALK;
            end
            S_WALK: begin
                if (i_sts.walk_match) begin
                    o_cmd.push = 1'b1;
                end else if (i_sts.at_zero) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.scan_prev = 1'b1;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state = i_sts.sp_one ? S_EMIT_RD : S_POP_B;
            end
            S_POP_B: begin
                o_cmd.cur_load = 1'b1;
                n_state = S_WALK;
            end
            S_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (out_free) begin
                    o_cmd.emit_ld = 1'b1;
                    if (i_sts.clen_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.emit_rd = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld && !i_out_ready;
        if (o_cmd.add || o_cmd.clear || o_cmd.emit_ld) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

### hw/rtl/euler_circuit_finder.sv
// Top level of the Euler circuit finder: controller and datapath.
//
// Input words carry a mode and an edge. An add word stores a directed edge and
// returns one word (accepted, or rejected when a vertex is out of range or the
// edge store is full). A clear word empties the store and returns one word. A
// run word classifies the stored live edges as Eulerian or not and then walks
// them from vertex 0 with a stack, returning the circuit one vertex per word,
// last word marked. Mode 3 is ignored and returns nothing.
// The vertex count register is written on its own channel; the user must
// write it only while idle, the block does not enforce this. Add and clear
// results appear in the cycle after acceptance. A run scans the stored edges
// for degrees, then in reachability passes (repeated until no flag changes,
// at most one pass per vertex), then walks: every walk step scans the edge
// store downward one entry per cycle from the newest edge. The edge store
// has a single read port. The result sits in an output register; a new word
// is taken in the cycle the previous result leaves. When the receiver
// stalls, the block holds its result and waits. Reset clears the edge store
// and sets 16 vertices.
module euler_circuit_finder
    import ecf_pkg::*;
#(
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_word,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // The register write is always taken at once.
    assign o_cfg_ready = 1'b1;

    ecf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_in_word.mode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ecf_datapath #(
        .MAX_EDGES (MAX_EDGES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_word (o_out_word)
    );

endmodule

### tb/testbench.sv
// Testbench of the Euler circuit finder: random and directed edge loads, clears and runs.
`timescale 1ns / 100ps

// Tracks the expected result words of the block and checks each accepted output word.
class circuit_scoreboard;
    ecf_pkg::t_out_word pending[$];
    logic [3:0] tails[63];
    logic [3:0] heads[63];
    bit         used[63];
    int         total;
    int         nv_reg;
    int         fails;
    int         vertex_words;
    int         runs;

    function new();
        total = 0;
        nv_reg = 16;
        fails = 0;
        vertex_words = 0;
        runs = 0;
        foreach (used[i]) used[i] = 0;
    endfunction

    function int vcount();
        int n;
        n = nv_reg;
        if (n == 0) n = 1;
        if (n > 16) n = 16;
        return n;
    endfunction

    function bit live(int e, int n);
        return !used[e] && tails[e] < n && heads[e] < n;
    endfunction

    function void push_word(logic [1:0] kind, logic [3:0] v, bit eul, bit last);
        ecf_pkg::t_out_word w;
        w.result_kind = kind;
        w.vertex_out  = v;
        w.is_eulerian = eul;
        w.is_last     = last;
        pending = {pending, w};
    endfunction

    // Balance of every vertex, then reachability from the lowest vertex with edges.
    function bit classify(int n);
        int indeg[16];
        int outdeg[16];
        bit seen[16];
        int work[16];
        int top;
        int start;
        int u;
        foreach (indeg[i]) begin
            indeg[i] = 0;
            outdeg[i] = 0;
            seen[i] = 0;
        end
        for (int e = 0; e < total; e++) begin
            if (live(e, n)) begin
                outdeg[tails[e]]++;
                indeg[heads[e]]++;
            end
        end
        for (int v = 0; v < n; v++)
            if (indeg[v] != outdeg[v]) return 0;
        start = n;
        for (int v = n - 1; v >= 0; v--)
            if (indeg[v] + outdeg[v] != 0) start = v;
        if (start == n) return 1;
        seen[start] = 1;
        work[0] = start;
        top = 1;
        while (top > 0) begin
            top--;
            u = work[top];
            for (int e = 0; e < total; e++) begin
                if (live(e, n) && tails[e] == u && !seen[heads[e]]) begin
                    seen[heads[e]] = 1;
                    work[top] = heads[e];
                    top++;
                end
            end
        end
        for (int v = 0; v < n; v++)
            if (!seen[v] && indeg[v] + outdeg[v] != 0) return 0;
        return 1;
    endfunction

    // Hierholzer walk from vertex 0, newest live out-edge first.
    function void walk(int n);
        bit eul;
        int stack[64];
        int sp;
        int circ[64];
        int clen;
        int cur;
        int found;
        eul = classify(n);
        stack[0] = 0;
        sp = 1;
        clen = 0;
        while (sp > 0) begin
            cur = stack[sp - 1];
            found = -1;
            for (int e = total - 1; e >= 0 && found < 0; e--)
                if (live(e, n) && tails[e] == cur) found = e;
            if (found >= 0) begin
                used[found] = 1;
                stack[sp] = heads[found];
                sp++;
            end else begin
                circ[clen] = cur;
                clen++;
                sp--;
            end
        end
        for (int i = clen - 1; i >= 0; i--)
            push_word(ecf_pkg::KIND_VERTEX, 4'(circ[i]), eul, i == 0);
        runs++;
    endfunction

    function void note_input(ecf_pkg::t_in_word w);
        int n;
        n = vcount();
        case (w.mode)
            ecf_pkg::MODE_ADD: begin
                if (w.src_vertex >= n || w.dst_vertex >= n || total >= 63) begin
                    push_word(ecf_pkg::KIND_REJECT, 4'd0, 0, 1);
                end else begin
                    tails[total] = w.src_vertex;
                    heads[total] = w.dst_vertex;
                    used[total] = 0;
                    total++;
                    push_word(ecf_pkg::KIND_ACCEPT, 4'd0, 0, 1);
                end
            end
            ecf_pkg::MODE_CLEAR: begin
                total = 0;
                foreach (used[i]) used[i] = 0;
                push_word(ecf_pkg::KIND_CLEARED, 4'd0, 0, 1);
            end
            ecf_pkg::MODE_RUN: walk(n);
            default: ;
        endcase
    endfunction

    function void check_output(ecf_pkg::t_out_word got);
        ecf_pkg::t_out_word exp;
        if (pending.size() == 0) begin
            $error("unexpected output word %h", got);
            fails++;
            return;
        end
        exp = pending.pop_front();
        if (got.result_kind == ecf_pkg::KIND_VERTEX) vertex_words++;
        if (got.result_kind !== exp.result_kind) begin
            $error("result_kind expected %0d actual %0d", exp.result_kind, got.result_kind);
            fails++;
        end
        if (got.vertex_out !== exp.vertex_out) begin
            $error("vertex_out expected %0d actual %0d", exp.vertex_out, got.vertex_out);
            fails++;
        end
        if (got.is_eulerian !== exp.is_eulerian) begin
            $error("is_eulerian expected %0d actual %0d", exp.is_eulerian, got.is_eulerian);
            fails++;
        end
        if (got.is_last !== exp.is_last) begin
            $error("is_last expected %0d actual %0d", exp.is_last, got.is_last);
            fails++;
        end
    endfunction
endclass

module testbench;
    import ecf_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in_word         i_in_word;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out_word        o_out_word;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;

    circuit_scoreboard board;
    int  sent;
    // While set, the output side stalls for a long stretch so the block backs up.
    bit  hold_request;
    bit  stim_done;

    euler_circuit_finder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // No gap half of the time, else mostly a short one and now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one input word and holds it until the block takes it. Valid stays
    // high afterwards so a word with no gap follows at once; a gap or a drain
    // drops it.
    task automatic send_word(logic [1:0] mode, logic [3:0] s, logic [3:0] d);
        t_in_word w;
        int g;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        w.mode = mode;
        w.src_vertex = s;
        w.dst_vertex = d;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_input(w);
        sent++;
    endtask

    task automatic add_edge(int s, int d);
        send_word(MODE_ADD, 4'(s), 4'(d));
    endtask

    // Waits until every expected word has arrived, then waits on so the
    // block settles (an ignored word returns nothing) before going on.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_nv(int value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= CFG_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.nv_reg = value;
    endtask

    // Loads a random closed walk over n vertices starting at vertex 0, so the
    // graph is Eulerian.
    task automatic load_circuit(int n, int len);
        int prev;
        int nxt;
        prev = 0;
        for (int i = 0; i < len - 1; i++) begin
            nxt = $urandom_range(0, n - 1);
            add_edge(prev, nxt);
            prev = nxt;
        end
        add_edge(prev, 0);
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        i_out_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready)
                board.check_output(o_out_word);
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_request = 0;
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= (gap_len() == 0) || ($urandom_range(0, 2) != 0);
            end
        end
    end

    initial begin
        int n;
        int r;
        board = new();
        sent = 0;
        hold_request = 0;
        stim_done = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty run, range limits, a triangle, an unbalanced
        // graph, the ignored mode and a small vertex count.
        send_word(MODE_RUN, 4'd0, 4'd0);
        add_edge(15, 15);
        add_edge(0, 15);
        add_edge(15, 0);
        add_edge(0, 1);
        add_edge(1, 2);
        add_edge(2, 0);
        send_word(MODE_RUN, 4'd0, 4'd0);
        send_word(MODE_RUN, 4'd0, 4'd0);
        add_edge(3, 4);
        send_word(2'd3, 4'hF, 4'hA);
        send_word(MODE_RUN, 4'd0, 4'd0);
        send_word(MODE_CLEAR, 4'd0, 4'd0);
        write_nv(0);
        add_edge(0, 0);
        add_edge(1, 0);
        send_word(MODE_RUN, 4'd0, 4'd0);
        write_nv(31);
        add_edge(5, 6);
        write_nv(4);
        add_edge(1, 2);
        add_edge(2, 1);
        send_word(MODE_RUN, 4'd0, 4'd0);
        send_word(MODE_CLEAR, 4'd0, 4'd0);

        // Fill the store past its limit while the output side holds off.
        write_nv(16);
        hold_request = 1;
        for (int i = 0; i < 64; i++) add_edge(i % 16, (i + 1) % 16);
        drain();
        send_word(MODE_RUN, 4'd0, 4'd0);
        send_word(MODE_CLEAR, 4'd0, 4'd0);

        // Random part: mostly closed walks with random content, some noise.
        while (sent < 165) begin
            if ($urandom_range(0, 7) == 0) begin
                r = $urandom_range(0, 3);
                write_nv(r == 0 ? 1 : (r == 1 ? 16 : $urandom_range(2, 31)));
            end
            n = board.vcount();
            send_word(MODE_CLEAR, 4'd0, 4'd0);
            load_circuit(n, $urandom_range(1, 8));
            if ($urandom_range(0, 1)) load_circuit(n, $urandom_range(1, 4));
            if ($urandom_range(0, 3) == 0)
                send_word(2'($urandom_range(0, 3)), 4'($urandom), 4'($urandom));
            send_word(MODE_RUN, 4'd0, 4'd0);
            if ($urandom_range(0, 3) == 0) send_word(MODE_RUN, 4'd0, 4'd0);
        end
        drain();
        stim_done = 1;
        repeat (50) @(posedge i_clk);
        $display("Sent %0d input words over %0d runs; %0d circuit vertices checked.",
                 sent, board.runs, board.vertex_words);
        if (board.fails == 0 && board.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end
endmodule
